[sv/pphd_pkg.sv]
`timescale 1ns / 1ps

package pphd_pkg;

  // Sensor converter width
  localparam int AdcBits = 10;

  // Magnitude of (sample - zero) * 100 * 2^16
  localparam int NumW = AdcBits + 7 + 16;
  localparam int CntW = $clog2(NumW);

  // Working width for saturation, term width for MAC, accumulator width
  localparam int WideW = 48;
  localparam int TermW = 33;
  localparam int AccW  = 68;

  // APB address width and register indexes
  localparam int PaddrW = 5;
  localparam logic [2:0] RegAdcZero  = 3'd0;
  localparam logic [2:0] RegAdcFull  = 3'd1;
  localparam logic [2:0] RegGainP    = 3'd2;
  localparam logic [2:0] RegGainI    = 3'd3;
  localparam logic [2:0] RegGainD    = 3'd4;
  localparam logic [2:0] RegIntLimit = 3'd5;

  typedef struct packed {
    logic [AdcBits-1:0] adc_zero;
    logic [AdcBits-1:0] adc_full;
    logic [31:0]        gain_p;
    logic [31:0]        gain_i;
    logic [31:0]        gain_d;
    logic [30:0]        int_limit;
  } cfg_t;

endpackage

[sv/pphd_cfg.sv]
`timescale 1ns / 1ps

module pphd_cfg import pphd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adc_zero  <= AdcBits'(260);
      cfg_q.adc_full  <= AdcBits'(65);
      cfg_q.gain_p    <= 32'd2516582;
      cfg_q.gain_i    <= 32'd16777;
      cfg_q.gain_d    <= 32'd0;
      cfg_q.int_limit <= 31'd6553600;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegAdcZero:  cfg_q.adc_zero  <= pwdata[AdcBits-1:0];
        RegAdcFull:  cfg_q.adc_full  <= pwdata[AdcBits-1:0];
        RegGainP:    cfg_q.gain_p    <= pwdata;
        RegGainI:    cfg_q.gain_i    <= pwdata;
        RegGainD:    cfg_q.gain_d    <= pwdata;
        RegIntLimit: cfg_q.int_limit <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      RegAdcZero:  prdata = 32'(cfg_q.adc_zero);
      RegAdcFull:  prdata = 32'(cfg_q.adc_full);
      RegGainP:    prdata = cfg_q.gain_p;
      RegGainI:    prdata = cfg_q.gain_i;
      RegGainD:    prdata = cfg_q.gain_d;
      RegIntLimit: prdata = {1'b0, cfg_q.int_limit};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[sv/pphd_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module pphd_div import pphd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumW-1:0]    dividend_i,
  input  logic [AdcBits-1:0] divisor_i,
  output logic               done_o,
  output logic [NumW-1:0]    quotient_o
);

  logic [NumW-1:0]    quo_q, quo_d;
  logic [AdcBits-1:0] rem_q, rem_d;
  logic [AdcBits-1:0] dsr_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [AdcBits:0]   rem_sh, rem_sub;
  logic               ge;

  // One shift/subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_d   = ge ? rem_sub[AdcBits-1:0] : rem_sh[AdcBits-1:0];
    quo_d   = {quo_q[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[sv/pphd_mac.sv]
`timescale 1ns / 1ps

// Sign-magnitude MAC: three gain*term products through one 32x16 multiplier,
// three 16-bit chunks per term, product registered before accumulation.
module pphd_mac import pphd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [31:0]             gain_p_i,
  input  logic [31:0]             gain_i_i,
  input  logic [31:0]             gain_d_i,
  input  logic signed [TermW-1:0] term_p_i,
  input  logic signed [TermW-1:0] term_i_i,
  input  logic signed [TermW-1:0] term_d_i,
  output logic                    done_o,
  output logic signed [AccW-1:0]  acc_o
);

  logic [TermW-1:0]       mag_q [3];
  logic [2:0]             neg_q;
  logic [1:0]             term_q, chunk_q;
  logic                   issue_q, pvalid_q, done_q;
  logic [47:0]            prod_q;
  logic [1:0]             pchunk_q;
  logic                   pneg_q;
  logic signed [AccW-1:0] acc_q;

  logic [31:0]            gain_sel;
  logic [TermW-1:0]       mag_sel;
  logic [47:0]            mag_ext;
  logic [15:0]            chunk_sel;
  logic                   neg_sel;
  logic [AccW-1:0]        addend;

  // Operand selection
  always_comb begin
    unique case (term_q)
      2'd0: begin gain_sel = gain_p_i; mag_sel = mag_q[0]; neg_sel = neg_q[0]; end
      2'd1: begin gain_sel = gain_i_i; mag_sel = mag_q[1]; neg_sel = neg_q[1]; end
      2'd2: begin gain_sel = gain_d_i; mag_sel = mag_q[2]; neg_sel = neg_q[2]; end
      default: begin gain_sel = '0; mag_sel = '0; neg_sel = 1'b0; end
    endcase
    mag_ext = 48'(mag_sel);
    unique case (chunk_q)
      2'd0:    chunk_sel = mag_ext[15:0];
      2'd1:    chunk_sel = mag_ext[31:16];
      2'd2:    chunk_sel = mag_ext[47:32];
      default: chunk_sel = '0;
    endcase
  end

  // Registered product placed at its chunk position
  assign addend = AccW'(prod_q) << {pchunk_q, 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q  <= 1'b0;
      pvalid_q <= 1'b0;
      done_q   <= 1'b0;
      term_q   <= '0;
      chunk_q  <= '0;
    end else begin
      done_q   <= pvalid_q & ~issue_q;
      pvalid_q <= issue_q;
      if (start_i) begin
        issue_q <= 1'b1;
        term_q  <= '0;
        chunk_q <= '0;
      end else if (issue_q) begin
        if (chunk_q == 2'd2) begin
          chunk_q <= '0;
          term_q  <= term_q + 1'b1;
          if (term_q == 2'd2) issue_q <= 1'b0;
        end else begin
          chunk_q <= chunk_q + 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q[0] <= term_p_i[TermW-1] ? TermW'(-term_p_i) : TermW'(term_p_i);
      mag_q[1] <= term_i_i[TermW-1] ? TermW'(-term_i_i) : TermW'(term_i_i);
      mag_q[2] <= term_d_i[TermW-1] ? TermW'(-term_d_i) : TermW'(term_d_i);
      neg_q    <= {term_d_i[TermW-1], term_i_i[TermW-1], term_p_i[TermW-1]};
      acc_q    <= '0;
    end else if (pvalid_q) begin
      acc_q <= pneg_q ? acc_q - $signed(addend) : acc_q + $signed(addend);
    end
    if (issue_q) begin
      prod_q   <= 48'(gain_sel) * 48'(chunk_sel);
      pchunk_q <= chunk_q;
      pneg_q   <= neg_sel;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

[sv/position_pid_hbridge_drive_unit.sv]
`timescale 1ns / 1ps

// PID position loop driving an H-bridge.
// Input channel (in_valid_i/in_ready_o) takes one word: a target position in
// whole percent and a raw sensor sample. Output channel (out_valid_o/
// out_ready_i) returns one word per input: saturated Q16.16 drive, measured
// position in Q16.16, direction and the two bridge input levels.
// Calibration points, gains and the integral clamp sit on an APB port;
// write them only while the block is idle.
// Steps from the accepting edge to out_valid_o: a prep step, the bit-serial
// position divider (33 quotient steps and its done flag), 4 steps for
// position, error, integral clamp and multiplier start, then the 9 passes
// through the shared 32x16 multiplier, drain, done and output load. Equal
// calibration points skip the divider. One word is in work at a time;
// in_ready_o is high only while the sequencer is idle, so a new word is
// taken only after the previous one has passed its output load.
// The result sits in an output register, so the next word is accepted while
// the previous result waits; a stalled receiver holds the block at its last
// step until the slot frees up. Reset restores the default calibration and
// gains and clears the integral and the stored previous error.
module position_pid_hbridge_drive_unit import pphd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [9:0]         target_position_i,
  input  logic [AdcBits-1:0]        adc_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [31:0]        drive_value_o,
  output logic signed [31:0]        measured_position_o,
  output logic                      direction_o,
  output logic                      bridge_in1_o,
  output logic                      bridge_in2_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPrep = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StPos  = 3'd3;
  localparam logic [2:0] StErr  = 3'd4;
  localparam logic [2:0] StInt  = 3'd5;
  localparam logic [2:0] StMacS = 3'd6;
  localparam logic [2:0] StMac  = 3'd7;

  cfg_t cfg;

  logic [2:0]               state_q, state_d;
  logic                     fin_q;
  logic signed [9:0]        tgt_q;
  logic [AdcBits-1:0]       smp_q;
  logic                     neg_q, zero_q;
  logic signed [31:0]       pos_q, err_q, integ_q, prev_q;
  logic signed [TermW-1:0]  deriv_q;
  logic                     out_valid_q;
  logic signed [31:0]       drive_q, meas_q;
  logic                     dir_q, in1_q, in2_q;

  logic signed [AdcBits:0]  diff, den;
  logic [AdcBits-1:0]       diff_mag, den_mag;
  logic [NumW-1:0]          num_mag, quo;
  logic                     div_start, div_done;
  logic                     mac_start, mac_done;
  logic signed [AccW-1:0]   acc;
  logic signed [WideW-1:0]  pos_w, err_w, int_w, lim_w;
  logic signed [TermW-1:0]  deriv_w;
  logic signed [AccW-1:0]   acc_sh;
  logic signed [31:0]       drive_w;
  logic                     out_free;

  function automatic logic signed [31:0] sat32w(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi, lo;
    hi = WideW'(32'sh7FFF_FFFF);
    lo = -hi - WideW'(1);
    if (v > hi)      sat32w = 32'sh7FFF_FFFF;
    else if (v < lo) sat32w = 32'sh8000_0000;
    else             sat32w = v[31:0];
  endfunction

  pphd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Position mapping operands
  always_comb begin
    diff     = $signed({1'b0, smp_q}) - $signed({1'b0, cfg.adc_zero});
    den      = $signed({1'b0, cfg.adc_full}) - $signed({1'b0, cfg.adc_zero});
    diff_mag = diff[AdcBits] ? AdcBits'(-diff) : diff[AdcBits-1:0];
    den_mag  = den[AdcBits] ? AdcBits'(-den) : den[AdcBits-1:0];
    num_mag  = (NumW'(diff_mag) * NumW'(100)) << 16;
  end

  assign div_start = (state_q == StPrep) && (den != '0);
  assign mac_start = (state_q == StMacS);

  pphd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_mag),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  pphd_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mac_start),
    .gain_p_i (cfg.gain_p),
    .gain_i_i (cfg.gain_i),
    .gain_d_i (cfg.gain_d),
    .term_p_i (TermW'(err_q)),
    .term_i_i (TermW'(integ_q)),
    .term_d_i (deriv_q),
    .done_o   (mac_done),
    .acc_o    (acc)
  );

  // Signed position, error, clamped integral, derivative
  always_comb begin
    pos_w   = zero_q ? '0 : (neg_q ? -WideW'(quo) : WideW'(quo));
    err_w   = (WideW'(tgt_q) <<< 16) - WideW'(pos_q);
    lim_w   = WideW'(cfg.int_limit);
    int_w   = WideW'(integ_q) + WideW'(err_q);
    if (int_w > lim_w)       int_w = lim_w;
    else if (int_w < -lim_w) int_w = -lim_w;
    deriv_w = TermW'(err_q) - TermW'(prev_q);
    acc_sh  = acc >>> 24;
    drive_w = sat32w(WideW'(acc_sh));
  end

  assign out_free = ~out_valid_q | out_ready_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StPrep;
      StPrep: state_d = (den != '0) ? StDiv : StPos;
      StDiv:  if (div_done) state_d = StPos;
      StPos:  state_d = StErr;
      StErr:  state_d = StInt;
      StInt:  state_d = StMacS;
      StMacS: state_d = StMac;
      StMac:  if (fin_q && out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
    end else begin
      state_q <= state_d;
      if (mac_start)                     fin_q <= 1'b0;
      else if (mac_done)                 fin_q <= 1'b1;
      if (state_q == StInt) begin
        integ_q <= int_w[31:0];
        prev_q  <= err_q;
      end
      if (state_q == StMac && fin_q && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                      out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && state_q == StIdle) begin
      tgt_q <= target_position_i;
      smp_q <= adc_sample_i;
    end
    if (state_q == StPrep) begin
      zero_q <= (den == '0);
      neg_q  <= diff[AdcBits] ^ den[AdcBits];
    end
    if (state_q == StPos) pos_q <= sat32w(pos_w);
    if (state_q == StErr) err_q <= sat32w(err_w);
    if (state_q == StInt) deriv_q <= deriv_w;
    if (state_q == StMac && fin_q && out_free) begin
      drive_q <= drive_w;
      meas_q  <= pos_q;
      dir_q   <= ~drive_w[31];
      if (drive_w > -32'sd65536 && drive_w < 32'sd65536) begin
        in1_q <= 1'b1;
        in2_q <= 1'b1;
      end else begin
        in1_q <= ~drive_w[31];
        in2_q <= drive_w[31];
      end
    end
  end

  assign in_ready_o          = (state_q == StIdle);
  assign out_valid_o         = out_valid_q;
  assign drive_value_o       = drive_q;
  assign measured_position_o = meas_q;
  assign direction_o         = dir_q;
  assign bridge_in1_o        = in1_q;
  assign bridge_in2_o        = in2_q;

endmodule
